FILE: design/ftd_pkg.sv
package ftd_pkg;

    localparam int unsigned NODES = 3;
    localparam int unsigned PAIRS = 6;

    typedef logic signed [31:0] t_q;
    typedef logic signed [63:0] t_prod;
    typedef logic signed [65:0] t_acc;

    typedef struct packed {
        t_q grad_x_a;
        t_q grad_x_b;
        t_q grad_x_c;
        t_q grad_z_a;
        t_q grad_z_b;
        t_q grad_z_c;
        t_q temp_a;
        t_q temp_b;
        t_q temp_c;
        t_q conductance_volume;
    } t_in_item;

    typedef struct packed {
        t_q rate_a;
        t_q rate_b;
        t_q rate_c;
    } t_out_item;

    // Unique entries of the symmetric element matrix: aa, ab, ac, bb, bc, cc.
    typedef struct packed {
        t_q [PAIRS-1:0] d;
        t_q [NODES-1:0] temp;
        t_q             kv;
    } t_mat_item;

    typedef struct packed {
        t_q [NODES-1:0] diff;
        t_q             kv;
    } t_diff_item;

    typedef logic [1:0] t_node_idx;

    localparam t_node_idx PAIR_I [PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam t_node_idx PAIR_J [PAIRS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    function automatic t_prod f_mul(input t_q a, input t_q b);
        f_mul = 64'(a) * 64'(b);
    endfunction

    // Q32.32 to Q16.16: round to nearest with ties upward, then saturate.
    function automatic t_q f_round_sat(input t_acc v);
        t_acc              t;
        logic signed [49:0] q;
        t = v + 66'sd32768;
        q = t[65:16];
        if (q > 50'sd2147483647) begin
            f_round_sat = 32'sh7FFFFFFF;
        end else if (q < -50'sd2147483648) begin
            f_round_sat = 32'sh80000000;
        end else begin
            f_round_sat = q[31:0];
        end
    endfunction

endpackage

FILE: design/ftd_matrix.sv
module ftd_matrix
    import ftd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_mat_item o_item
);

    logic                   r_v1;
    logic                   r_v2;
    t_prod [PAIRS-1:0]      r_px;
    t_prod [PAIRS-1:0]      r_pz;
    t_q    [NODES-1:0]      r_temp1;
    t_q                     r_kv1;
    t_mat_item              r_out;

    logic                   rdy1;
    logic                   rdy0;
    t_q    [NODES-1:0]      gx;
    t_q    [NODES-1:0]      gz;
    t_prod [PAIRS-1:0]      n_px;
    t_prod [PAIRS-1:0]      n_pz;
    t_mat_item              n_out;

    assign rdy1    = !r_v2 || i_ready;
    assign rdy0    = !r_v1 || rdy1;
    assign o_ready = rdy0;
    assign o_valid = r_v2;
    assign o_item  = r_out;

    assign gx[0] = i_item.grad_x_a;
    assign gx[1] = i_item.grad_x_b;
    assign gx[2] = i_item.grad_x_c;
    assign gz[0] = i_item.grad_z_a;
    assign gz[1] = i_item.grad_z_b;
    assign gz[2] = i_item.grad_z_c;

    always_comb begin
        for (int k = 0; k < PAIRS; k++) begin
            n_px[k] = f_mul(gx[PAIR_I[k]], gx[PAIR_J[k]]);
            n_pz[k] = f_mul(gz[PAIR_I[k]], gz[PAIR_J[k]]);
        end
    end

    always_comb begin
        n_out = r_out;
        for (int k = 0; k < PAIRS; k++) begin
            n_out.d[k] = f_round_sat(66'(r_px[k]) + 66'(r_pz[k]));
        end
        n_out.temp = r_temp1;
        n_out.kv   = r_kv1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v1 <= i_valid;
            end
            if (rdy1) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_valid) begin
            r_px       <= n_px;
            r_pz       <= n_pz;
            r_temp1[0] <= i_item.temp_a;
            r_temp1[1] <= i_item.temp_b;
            r_temp1[2] <= i_item.temp_c;
            r_kv1      <= i_item.conductance_volume;
        end
        if (rdy1 && r_v1) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: design/ftd_flux.sv
module ftd_flux
    import ftd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_mat_item  i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_diff_item o_item
);

    logic                          r_v1;
    logic                          r_v2;
    t_prod [NODES-1:0][NODES-1:0]  r_p;
    t_q                            r_kv1;
    t_diff_item                    r_out;

    logic                          rdy1;
    logic                          rdy0;
    t_q    [NODES-1:0][NODES-1:0]  dm;
    t_prod [NODES-1:0][NODES-1:0]  n_p;
    t_diff_item                    n_out;

    assign rdy1    = !r_v2 || i_ready;
    assign rdy0    = !r_v1 || rdy1;
    assign o_ready = rdy0;
    assign o_valid = r_v2;
    assign o_item  = r_out;

    always_comb begin
        dm = '0;
        for (int k = 0; k < PAIRS; k++) begin
            dm[PAIR_I[k]][PAIR_J[k]] = i_item.d[k];
            dm[PAIR_J[k]][PAIR_I[k]] = i_item.d[k];
        end
        for (int i = 0; i < NODES; i++) begin
            for (int j = 0; j < NODES; j++) begin
                n_p[i][j] = f_mul(dm[i][j], i_item.temp[j]);
            end
        end
    end

    always_comb begin
        n_out = r_out;
        for (int i = 0; i < NODES; i++) begin
            n_out.diff[i] = f_round_sat(66'(r_p[i][0]) + 66'(r_p[i][1]) + 66'(r_p[i][2]));
        end
        n_out.kv = r_kv1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v1 <= i_valid;
            end
            if (rdy1) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_valid) begin
            r_p   <= n_p;
            r_kv1 <= i_item.kv;
        end
        if (rdy1 && r_v1) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: design/ftd_scale.sv
module ftd_scale
    import ftd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_diff_item i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_item
);

    logic                r_v1;
    logic                r_v2;
    t_prod [NODES-1:0]   r_p;
    t_out_item           r_out;

    logic                rdy1;
    logic                rdy0;
    t_prod [NODES-1:0]   n_p;
    t_out_item           n_out;

    assign rdy1    = !r_v2 || i_ready;
    assign rdy0    = !r_v1 || rdy1;
    assign o_ready = rdy0;
    assign o_valid = r_v2;
    assign o_item  = r_out;

    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            n_p[i] = f_mul(i_item.diff[i], i_item.kv);
        end
    end

    always_comb begin
        n_out.rate_a = f_round_sat(66'(r_p[0]));
        n_out.rate_b = f_round_sat(66'(r_p[1]));
        n_out.rate_c = f_round_sat(66'(r_p[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v1 <= i_valid;
            end
            if (rdy1) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_valid) begin
            r_p <= n_p;
        end
        if (rdy1 && r_v1) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: design/fem_triangle_heat_diffusion_rate.sv
// Throughput: one item per cycle while i_out_ready holds; three multiply stages,
// each followed by a round-and-saturate stage, set the depth.
// Reset is synchronous and active low; it clears only the valid bits of the
// pipeline, and the block accepts an item in the first cycle after reset.
module fem_triangle_heat_diffusion_rate
    import ftd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic       mat_valid;
    logic       mat_ready;
    t_mat_item  mat_item;
    logic       diff_valid;
    logic       diff_ready;
    t_diff_item diff_item;

    ftd_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (mat_valid),
        .i_ready (mat_ready),
        .o_item  (mat_item)
    );

    ftd_flux u_flux (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mat_valid),
        .o_ready (mat_ready),
        .i_item  (mat_item),
        .o_valid (diff_valid),
        .i_ready (diff_ready),
        .o_item  (diff_item)
    );

    ftd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (diff_valid),
        .o_ready (diff_ready),
        .i_item  (diff_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule
